### sv/sfd_pkg.sv
package sfd_pkg;

	localparam logic [7:0] PRE0 = 8'h24;
	localparam logic [7:0] PRE1 = 8'h4D;
	localparam logic [7:0] PRE2 = 8'h3E;

	typedef enum logic [2:0] {
		PH_HUNT0 = 3'd0,
		PH_HUNT1 = 3'd1,
		PH_HUNT2 = 3'd2,
		PH_SIZE  = 3'd3,
		PH_CODE  = 3'd4,
		PH_BODY  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  code;
		logic [7:0]  data;
		logic [7:0]  index;
		logic [7:0]  len;
		logic        last;
	} result_t;

endpackage

### sv/sfd_parser.sv
module sfd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        rx_byte,
	output logic              res_valid,
	output sfd_pkg::result_t  res
);
	import sfd_pkg::*;

	phase_t     phase_q, phase_d;
	logic [7:0] size_q, size_d;
	logic [7:0] code_q, code_d;
	logic [7:0] count_q, count_d;
	logic [7:0] xor_q, xor_d;
	logic       in_payload;
	logic [7:0] xor_next;

	assign in_payload = count_q < size_q;
	assign xor_next   = xor_q ^ rx_byte;

	always_comb begin
		phase_d = phase_q;
		size_d  = size_q;
		code_d  = code_q;
		count_d = count_q;
		xor_d   = xor_q;
		unique case (phase_q)
			PH_HUNT0: phase_d = (rx_byte == PRE0) ? PH_HUNT1 : PH_HUNT0;
			PH_HUNT1: phase_d = (rx_byte == PRE1) ? PH_HUNT2 : PH_HUNT0;
			PH_HUNT2: phase_d = (rx_byte == PRE2) ? PH_SIZE : PH_HUNT0;
			PH_SIZE: begin
				size_d  = rx_byte;
				xor_d   = rx_byte;
				count_d = '0;
				code_d  = '0;
				phase_d = PH_CODE;
			end
			PH_CODE: begin
				code_d  = rx_byte;
				xor_d   = xor_next;
				phase_d = PH_BODY;
			end
			PH_BODY: begin
				xor_d = xor_next;
				if (in_payload) begin
					count_d = count_q + 8'd1;
				end else begin
					phase_d = PH_HUNT0;
				end
			end
			default: phase_d = (rx_byte == PRE0) ? PH_HUNT1 : PH_HUNT0;
		endcase
	end

	always_comb begin
		res_valid = 1'b0;
		res.kind  = KIND_DATA;
		res.code  = code_q;
		res.data  = '0;
		res.index = '0;
		res.len   = size_q;
		res.last  = 1'b0;
		if (phase_q == PH_BODY) begin
			res_valid = 1'b1;
			if (in_payload) begin
				res.data  = rx_byte;
				res.index = count_q;
			end else begin
				res.kind = (xor_next == 8'd0) ? KIND_GOOD : KIND_BAD;
				res.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			size_q  <= '0;
			code_q  <= '0;
			count_q <= '0;
			xor_q   <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			size_q  <= size_d;
			code_q  <= code_d;
			count_q <= count_d;
			xor_q   <= xor_d;
		end
	end

endmodule

### sv/sfd_out_reg.sv
module sfd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sfd_pkg::result_t  res,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [31:0]       m_tdata,  // msg_code, payload_byte, byte_index, payload_len
	output logic [1:0]        m_tuser,  // kind
	output logic              m_tlast   // frame_last
);
	import sfd_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.len, res_s2.index, res_s2.data, res_s2.code};
	assign m_tuser  = res_s2.kind;
	assign m_tlast  = res_s2.last;

endmodule

### sv/serial_frame_deframer_xor_core.sv
// datapath: an accepted byte goes into the input register, and its result into the result register
// throughput: one byte per cycle; a stalled result holds the input register, no byte is dropped
// preamble, size and code bytes give no result; payload and checksum bytes give one each
// reset: arst_n low clears the hunt to the first preamble byte and empties both registers
// no clearing pass after reset, bytes are taken on the first cycle
module serial_frame_deframer_xor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // msg_code, payload_byte, byte_index, payload_len
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast    // frame_last
);
	import sfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_ready;
	logic       consume;
	logic       res_valid;
	result_t    res;

	assign out_ready = !m_tvalid || m_tready;
	assign consume   = valid_s1 && out_ready;
	assign s_tready  = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	sfd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (consume),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	sfd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (consume && res_valid),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// frame end carries a checksum verdict, payload results never do
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser != KIND_DATA)))
		else $error("tlast does not match result kind");

	// frame end result has zero payload byte and index
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[23:8] == 16'd0))
		else $error("frame end result carries payload fields");

	// payload index stays below the declared length
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[23:16] < m_tdata[31:24]))
		else $error("payload index beyond declared length");

	// input side only stalls while a byte waits in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without a pending byte");

endmodule
